@@ src/bdeg_pkg.sv @@
`timescale 1ns / 1ps
package bdeg_pkg;
	localparam int NBTN = 5;
	localparam int MAXRES = 6;
	localparam int TIME_BITS_DEF = 32;
	localparam int HISTORY_BITS_DEF = 8;
	localparam int NCFG = 7;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [2:0] {
		CFG_POLL = 3'd0,
		CFG_DEBOUNCE = 3'd1,
		CFG_LONG = 3'd2,
		CFG_RDELAY = 3'd3,
		CFG_RPERIOD = 3'd4,
		CFG_FAST_AFTER = 3'd5,
		CFG_FAST_PERIOD = 3'd6
	} cfg_idx_t;

	typedef enum logic [3:0] {
		EV_VDN = 4'd0,
		EV_PREV = 4'd1,
		EV_PREV_HOLD = 4'd2,
		EV_NEXT = 4'd3,
		EV_NEXT_HOLD = 4'd4,
		EV_VUP = 4'd5,
		EV_PLAY = 4'd6,
		EV_MENU = 4'd7,
		EV_MODE = 4'd8,
		EV_NONE = 4'd15
	} ev_t;

	localparam int IDX_VDN = 0;
	localparam int IDX_PLAY = 2;
	localparam int IDX_VUP = 4;

	typedef struct packed {
		logic [7:0]  poll_interval_ms;
		logic [3:0]  debounce_samples;
		logic [15:0] long_press_ms;
		logic [15:0] first_rpt_ms;
		logic [15:0] repeat_period_ms;
		logic [15:0] fast_after_ms;
		logic [15:0] fast_period_ms;
	} cfg_t;

	// Events one lane found in one tick, in emission order.
	typedef struct packed {
		ev_t first;
		ev_t second;
		ev_t third;
	} lane_ev_t;

	function automatic ev_t press_code(input int i);
		case (i)
			0: return EV_VDN;
			1: return EV_PREV;
			3: return EV_NEXT;
			4: return EV_VUP;
			default: return EV_NONE;
		endcase
	endfunction

	function automatic ev_t repeat_code(input int i);
		case (i)
			0: return EV_VDN;
			1: return EV_PREV_HOLD;
			3: return EV_NEXT_HOLD;
			4: return EV_VUP;
			default: return EV_NONE;
		endcase
	endfunction
endpackage

@@ src/bdeg_if.sv @@
`timescale 1ns / 1ps
interface bdeg_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic [4:0]  raw_levels;
	modport source(output valid, now_ms, raw_levels, input ready);
	modport sink(input valid, now_ms, raw_levels, output ready);
endinterface

interface bdeg_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] event_code;
	logic       last_event;
	modport source(output valid, event_code, last_event, input ready);
	modport sink(input valid, event_code, last_event, output ready);
endinterface

@@ src/button_debounce_event_generator_top.sv @@
`timescale 1ns / 1ps
// Channel  | Dir | Payload                        | Handshake
// poll     | in  | now_ms[31:0], raw_levels[4:0]  | valid/ready
// evt      | out | event_code[3:0], last_event    | valid/ready
// cfg      | in  | cfg_we, cfg_idx[2:0], cfg_data | write strobe
// Five lanes evaluate each taken tick in parallel, and the
// merge stage registers up to six events, then shows one per cycle while the
// receiver is ready; the next tick is taken in the cycle its predecessor's last
// event leaves. Reset clears all state but the event list to zero and loads
// register defaults. An output stall holds the current event.
module button_debounce_event_generator_top #(
	parameter int TIME_BITS = bdeg_pkg::TIME_BITS_DEF,
	parameter int HISTORY_BITS = bdeg_pkg::HISTORY_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bdeg_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bdeg_pkg::CFG_W-1:0]       cfg_data,
	bdeg_in_if.sink                          poll,
	bdeg_out_if.source                       evt
);
	bdeg_pkg::cfg_t cfg_q;
	logic [TIME_BITS-1:0] last_q, now;
	logic chord_q, take, step, free;
	logic [bdeg_pkg::NBTN-1:0] down;
	bdeg_pkg::lane_ev_t evs [bdeg_pkg::NBTN];
	bdeg_pkg::ev_t mode_ev;

	// Hold configuration; the host must write it only while no tick is in flight; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{8'd5, 4'd4, 16'd600, 16'd400, 16'd100, 16'd1200, 16'd50};
		end else if (cfg_we) begin
			unique case (cfg_idx)
				bdeg_pkg::CFG_POLL: cfg_q.poll_interval_ms <= cfg_data[7:0];
				bdeg_pkg::CFG_DEBOUNCE: cfg_q.debounce_samples <= cfg_data[3:0];
				bdeg_pkg::CFG_LONG: cfg_q.long_press_ms <= cfg_data;
				bdeg_pkg::CFG_RDELAY: cfg_q.first_rpt_ms <= cfg_data;
				bdeg_pkg::CFG_RPERIOD: cfg_q.repeat_period_ms <= cfg_data;
				bdeg_pkg::CFG_FAST_AFTER: cfg_q.fast_after_ms <= cfg_data;
				bdeg_pkg::CFG_FAST_PERIOD: cfg_q.fast_period_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	assign now = poll.now_ms[TIME_BITS-1:0];
	assign poll.ready = free;
	assign take = poll.valid && free;
	// Drop the tick when the poll interval has not yet passed.
	assign step = take && ((now - last_q) >= TIME_BITS'(cfg_q.poll_interval_ms));

	for (genvar i = 0; i < bdeg_pkg::NBTN; i++) begin : g_lane
		bdeg_lane #(.IDX(i), .TIME_BITS(TIME_BITS), .HISTORY_BITS(HISTORY_BITS)) u_lane (
			.clk, .arst_n, .step, .now,
			.pressed(!poll.raw_levels[i]),
			.muted(chord_q && (i == bdeg_pkg::IDX_VDN || i == bdeg_pkg::IDX_VUP)),
			.cfg(cfg_q), .down(down[i]), .evs(evs[i])
		);
	end

	assign mode_ev = (down[bdeg_pkg::IDX_VDN] && down[bdeg_pkg::IDX_VUP] && !chord_q)
		? bdeg_pkg::EV_MODE : bdeg_pkg::EV_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			chord_q <= 1'b0;
		end else if (step) begin
			last_q <= now;
			if (down[bdeg_pkg::IDX_VDN] && down[bdeg_pkg::IDX_VUP]) chord_q <= 1'b1;
			else if (!down[bdeg_pkg::IDX_VDN] && !down[bdeg_pkg::IDX_VUP]) chord_q <= 1'b0;
		end
	end

	bdeg_merge u_merge (
		.clk, .arst_n, .load(step), .evs, .mode_ev,
		.nxt_free(free), .res(evt)
	);
endmodule

@@ src/bdeg_lane.sv @@
`timescale 1ns / 1ps
// One button: debounce history, press bookkeeping and per-tick events.
module bdeg_lane #(
	parameter int IDX = 0,
	parameter int TIME_BITS = bdeg_pkg::TIME_BITS_DEF,
	parameter int HISTORY_BITS = bdeg_pkg::HISTORY_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [TIME_BITS-1:0] now,
	input  logic                 pressed,
	input  logic                 muted,
	input  bdeg_pkg::cfg_t       cfg,
	output logic                 down,
	output bdeg_pkg::lane_ev_t   evs
);
	logic [HISTORY_BITS-1:0] hist_q, hist_d, dmask, h;
	logic                    down_q, long_q;
	logic [TIME_BITS-1:0]    ptime_q, due_q;
	logic                    down_d, long_d;
	logic [TIME_BITS-1:0]    ptime_d, due_d, held, diff, per;
	logic [3:0]              ns;
	bdeg_pkg::ev_t           e0, e1, e2;

	always_comb begin
		ns = cfg.debounce_samples;
		if (ns == 4'd0) ns = 4'd1;
		if (32'(ns) > HISTORY_BITS) ns = 4'(HISTORY_BITS);
		dmask = HISTORY_BITS'((9'd1 << ns) - 9'd1);
		hist_d = {hist_q[HISTORY_BITS-2:0], pressed};
		h = hist_d & dmask;
		down_d = down_q;
		long_d = long_q;
		ptime_d = ptime_q;
		due_d = due_q;
		e0 = bdeg_pkg::EV_NONE;
		e1 = bdeg_pkg::EV_NONE;
		e2 = bdeg_pkg::EV_NONE;
		if (!down_q && h == dmask) begin
			down_d = 1'b1;
			long_d = 1'b0;
			ptime_d = now;
			due_d = now + TIME_BITS'(cfg.first_rpt_ms);
			e0 = bdeg_pkg::press_code(IDX);
		end else if (down_q && h == '0) begin
			down_d = 1'b0;
			if (!long_q && IDX == bdeg_pkg::IDX_PLAY) e0 = bdeg_pkg::EV_PLAY;
		end
		held = now - ptime_d;
		diff = now - due_d;
		per = (held >= TIME_BITS'(cfg.fast_after_ms)) ? TIME_BITS'(cfg.fast_period_ms)
			: TIME_BITS'(cfg.repeat_period_ms);
		if (down_d) begin
			if (!long_d && IDX == bdeg_pkg::IDX_PLAY
				&& held >= TIME_BITS'(cfg.long_press_ms)) begin
				long_d = 1'b1;
				e1 = bdeg_pkg::EV_MENU;
			end
			if (!muted && bdeg_pkg::repeat_code(IDX) != bdeg_pkg::EV_NONE
				&& !diff[TIME_BITS-1]) begin
				e2 = bdeg_pkg::repeat_code(IDX);
				due_d = now + per;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			down_q <= 1'b0;
			long_q <= 1'b0;
			ptime_q <= '0;
			due_q <= '0;
		end else if (step) begin
			hist_q <= hist_d;
			down_q <= down_d;
			long_q <= long_d;
			ptime_q <= ptime_d;
			due_q <= due_d;
		end
	end

	assign down = down_d;
	assign evs = '{first: e0, second: e1, third: e2};
endmodule

@@ src/bdeg_merge.sv @@
`timescale 1ns / 1ps
// Pack lane events in button order, then the mode event, into a six-slot list, then drain it.
module bdeg_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  bdeg_pkg::lane_ev_t   evs [bdeg_pkg::NBTN],
	input  bdeg_pkg::ev_t        mode_ev,
	output logic                 nxt_free,
	bdeg_out_if.source           res
);
	localparam int NS = bdeg_pkg::NBTN * 3 + 1;
	bdeg_pkg::ev_t list_q [bdeg_pkg::MAXRES];
	bdeg_pkg::ev_t list_d [bdeg_pkg::MAXRES];
	logic [2:0] cnt_q, pos_q, cnt_d;
	logic busy;
	bdeg_pkg::ev_t flat [NS];

	always_comb begin
		for (int i = 0; i < bdeg_pkg::NBTN; i++) begin
			flat[i*3] = evs[i].first;
			flat[i*3+1] = evs[i].second;
			flat[i*3+2] = evs[i].third;
		end
		flat[NS-1] = mode_ev;
		for (int k = 0; k < bdeg_pkg::MAXRES; k++) list_d[k] = bdeg_pkg::EV_NONE;
		cnt_d = '0;
		for (int i = 0; i < NS; i++) begin
			if (flat[i] != bdeg_pkg::EV_NONE && cnt_d < 3'(bdeg_pkg::MAXRES)) begin
				list_d[cnt_d] = flat[i];
				cnt_d = cnt_d + 3'd1;
			end
		end
	end

	assign busy = cnt_q != '0;
	assign res.valid = busy;
	assign res.event_code = list_q[pos_q];
	assign res.last_event = (pos_q + 3'd1) == cnt_q;
	// Accept a new tick while idle or while the final event is being taken.
	assign nxt_free = !busy || (res.ready && res.last_event);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pos_q <= '0;
		end else if (load) begin
			cnt_q <= cnt_d;
			pos_q <= '0;
		end else if (busy && res.ready) begin
			if (res.last_event) cnt_q <= '0;
			pos_q <= pos_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) list_q <= list_d;
	end
endmodule

@@ src/bdeg_checker.sv @@
`timescale 1ns / 1ps
module bdeg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] event_code,
	input logic       last_event
);
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_code <= 4'd8) else $error("bad event code");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_code)) else $error("stall");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_event |-> !in_ready) else $error("took tick mid burst");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("not ready while idle");
endmodule

bind button_debounce_event_generator_top bdeg_checker u_chk (
	.clk, .arst_n,
	.in_ready(poll.ready),
	.out_valid(evt.valid), .out_ready(evt.ready),
	.event_code(evt.event_code), .last_event(evt.last_event)
);

@@ test/button_debounce_event_generator_top_test.sv @@
`timescale 1ns / 1ps
module button_debounce_event_generator_top_test;
	typedef struct packed {
		logic [31:0] now_ms;
		logic [4:0]  raw_levels;
	} poll_t;

	typedef struct packed {
		bdeg_pkg::ev_t code;
		logic          last;
	} evt_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [bdeg_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [bdeg_pkg::CFG_W-1:0] cfg_data;

	bdeg_in_if poll ();
	bdeg_out_if evt ();

	button_debounce_event_generator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.poll(poll.sink),
		.evt(evt.source)
	);

	// Shadow of the block's registers and state
	logic [7:0]  sh_poll_ms;
	logic [3:0]  sh_samples;
	logic [15:0] sh_long_ms;
	logic [15:0] sh_rdelay;
	logic [15:0] sh_rperiod;
	logic [15:0] sh_fast_after;
	logic [15:0] sh_fast_period;
	logic [7:0]  btn_hist [bdeg_pkg::NBTN];
	logic        btn_down [bdeg_pkg::NBTN];
	logic        btn_long [bdeg_pkg::NBTN];
	logic [31:0] btn_press_at [bdeg_pkg::NBTN];
	logic [31:0] btn_repeat_at [bdeg_pkg::NBTN];
	logic        vol_chord;
	logic [31:0] last_tick;

	poll_t pending_polls [$];
	evt_t  expected_events [$];
	int    fail_count;
	int    idle_cycles;
	bit    in_acc;
	bit    hold_sink;
	int    hold_count;

	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic shadow_reset();
		sh_poll_ms = 8'd5;
		sh_samples = 4'd4;
		sh_long_ms = 16'd600;
		sh_rdelay = 16'd400;
		sh_rperiod = 16'd100;
		sh_fast_after = 16'd1200;
		sh_fast_period = 16'd50;
		for (int i = 0; i < bdeg_pkg::NBTN; i++) begin
			btn_hist[i] = '0;
			btn_down[i] = 1'b0;
			btn_long[i] = 1'b0;
			btn_press_at[i] = '0;
			btn_repeat_at[i] = '0;
		end
		vol_chord = 1'b0;
		last_tick = '0;
	endtask

	// Append one event unless it is a blank code or the tick is full
	function automatic void push_event(bdeg_pkg::ev_t code, ref evt_t tick_evts [$]);
		evt_t e;
		if (code == bdeg_pkg::EV_NONE || tick_evts.size() >= bdeg_pkg::MAXRES) return;
		e.code = code;
		e.last = 1'b0;
		tick_evts.push_back(e);
	endfunction

	// Advance the shadow by one poll and queue the events it raises
	task automatic predict_tick(input poll_t p);
		evt_t tick_evts [$];
		int nsamp;
		logic [7:0] dmask;
		logic [7:0] h;
		logic pressed;
		logic [31:0] held;
		logic [31:0] diff;
		logic muted;
		bdeg_pkg::ev_t click_c;
		bdeg_pkg::ev_t long_c;
		nsamp = (sh_samples == 0) ? 1 : (sh_samples > 8) ? 8 : sh_samples;
		dmask = 8'((9'd1 << nsamp) - 1);
		if (p.now_ms - last_tick < {24'd0, sh_poll_ms}) return;
		last_tick = p.now_ms;
		for (int i = 0; i < bdeg_pkg::NBTN; i++) begin
			pressed = ~p.raw_levels[i];
			btn_hist[i] = {btn_hist[i][6:0], pressed};
			h = btn_hist[i] & dmask;
			click_c = (i == bdeg_pkg::IDX_PLAY) ? bdeg_pkg::EV_PLAY : bdeg_pkg::EV_NONE;
			long_c = (i == bdeg_pkg::IDX_PLAY) ? bdeg_pkg::EV_MENU : bdeg_pkg::EV_NONE;
			if (!btn_down[i] && h == dmask) begin
				btn_down[i] = 1'b1;
				btn_long[i] = 1'b0;
				btn_press_at[i] = p.now_ms;
				btn_repeat_at[i] = p.now_ms + {16'd0, sh_rdelay};
				push_event(bdeg_pkg::press_code(i), tick_evts);
			end else if (btn_down[i] && h == 0) begin
				btn_down[i] = 1'b0;
				if (!btn_long[i]) push_event(click_c, tick_evts);
			end
			if (btn_down[i]) begin
				held = p.now_ms - btn_press_at[i];
				muted = vol_chord && (i == bdeg_pkg::IDX_VDN || i == bdeg_pkg::IDX_VUP);
				diff = p.now_ms - btn_repeat_at[i];
				if (!btn_long[i] && long_c != bdeg_pkg::EV_NONE
					&& held >= {16'd0, sh_long_ms}) begin
					btn_long[i] = 1'b1;
					push_event(long_c, tick_evts);
				end
				if (!muted && bdeg_pkg::repeat_code(i) != bdeg_pkg::EV_NONE && !diff[31]) begin
					push_event(bdeg_pkg::repeat_code(i), tick_evts);
					btn_repeat_at[i] = p.now_ms + ((held >= {16'd0, sh_fast_after}) ?
						{16'd0, sh_fast_period} : {16'd0, sh_rperiod});
				end
			end
		end
		if (btn_down[bdeg_pkg::IDX_VDN] && btn_down[bdeg_pkg::IDX_VUP] && !vol_chord) begin
			vol_chord = 1'b1;
			push_event(bdeg_pkg::EV_MODE, tick_evts);
		end else if (!btn_down[bdeg_pkg::IDX_VDN] && !btn_down[bdeg_pkg::IDX_VUP]) begin
			vol_chord = 1'b0;
		end
		if (tick_evts.size() > 0) tick_evts[tick_evts.size()-1].last = 1'b1;
		foreach (tick_evts[k]) expected_events.push_back(tick_evts[k]);
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Driver: present queued polls, change inputs at the falling edge
	int drv_gap;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_acc) begin
				drv_gap = gap_len();
			end
			if (poll.valid && !in_acc) begin
				// hold the current transaction
			end else if (drv_gap > 0) begin
				drv_gap--;
				poll.valid <= 1'b0;
			end else if (pending_polls.size() > 0) begin
				poll.valid <= 1'b1;
				{poll.now_ms, poll.raw_levels} <= pending_polls.pop_front();
			end else begin
				poll.valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure
	int snk_gap;
	always @(negedge clk) begin
		if (hold_count > 0) begin
			hold_count--;
			evt.ready <= 1'b0;
		end else if (hold_sink) begin
			evt.ready <= 1'b1;
		end else if (snk_gap > 0) begin
			snk_gap--;
			evt.ready <= 1'b0;
		end else begin
			snk_gap = gap_len();
			evt.ready <= 1'b1;
		end
	end

	// Monitor: predict on accepted polls, check accepted events
	evt_t got;
	evt_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			in_acc = poll.valid && poll.ready;
			if (in_acc)
				predict_tick({poll.now_ms, poll.raw_levels});
			if (evt.valid && evt.ready) begin
				got.code = bdeg_pkg::ev_t'(evt.event_code);
				got.last = evt.last_event;
				if (expected_events.size() == 0) begin
					report_mismatch($sformatf("unexpected event %0d", evt.event_code));
				end else begin
					want = expected_events.pop_front();
					if (got.code != want.code)
						report_mismatch($sformatf("event_code %0d, want %0d",
							got.code, want.code));
					if (got.last != want.last)
						report_mismatch($sformatf("last_event %0b, want %0b",
							got.last, want.last));
				end
			end
			if (in_acc || (evt.valid && evt.ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("button_debounce_event_generator_top_test failed");
				$finish;
			end
		end
	end

	// Stimulus state: a running clock and button levels
	logic [31:0] clock_ms;

	task automatic add_poll(input int step, input logic [4:0] lv);
		poll_t p;
		clock_ms = clock_ms + step;
		p.now_ms = clock_ms;
		p.raw_levels = lv;
		pending_polls.push_back(p);
	endtask

	task automatic drain();
		while (pending_polls.size() > 0 || poll.valid || expected_events.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input bdeg_pkg::cfg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bdeg_pkg::CFG_POLL: sh_poll_ms = val[7:0];
			bdeg_pkg::CFG_DEBOUNCE: sh_samples = val[3:0];
			bdeg_pkg::CFG_LONG: sh_long_ms = val;
			bdeg_pkg::CFG_RDELAY: sh_rdelay = val;
			bdeg_pkg::CFG_RPERIOD: sh_rperiod = val;
			bdeg_pkg::CFG_FAST_AFTER: sh_fast_after = val;
			default: sh_fast_period = val;
		endcase
	endtask

	// Hold a random set of buttons for a while, then release
	task automatic press_sequence(input int nticks, input int step);
		logic [4:0] held_mask;
		held_mask = 5'($urandom());
		for (int t = 0; t < nticks; t++) begin
			if ($urandom_range(0, 19) == 0) add_poll(step, 5'($urandom()));
			else add_poll(step, ~held_mask);
		end
		for (int t = 0; t < 9; t++) add_poll(step, 5'h1f);
	endtask

	task automatic random_phase(input int count, input int step);
		int n;
		int len;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) < 8) begin
				len = $urandom_range(3, 40);
				press_sequence(len, step);
				n += len + 9;
			end else begin
				add_poll($urandom_range(0, 2 * step), 5'($urandom()));
				n++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = bdeg_pkg::CFG_POLL;
		cfg_data = '0;
		poll.valid = 1'b0;
		poll.now_ms = '0;
		poll.raw_levels = 5'h1f;
		evt.ready = 1'b0;
		fail_count = 0;
		idle_cycles = 0;
		in_acc = 1'b0;
		drv_gap = 0;
		snk_gap = 0;
		hold_sink = 1'b0;
		hold_count = 0;
		clock_ms = 32'd10;
		shadow_reset();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: defaults, chord, play long press, a jump of the clock near its top value
		add_poll(2, 5'h1f);
		for (int t = 0; t < 16; t++) add_poll(50, 5'h00);
		for (int t = 0; t < 5; t++) add_poll(50, 5'h1f);
		clock_ms = 32'hffff_ffd0;
		for (int t = 0; t < 3; t++) add_poll(5, 5'h1b);
		drain();

		// Extremes: single sample, zero delays and periods, every poll counts
		write_reg(bdeg_pkg::CFG_POLL, 16'd0);
		write_reg(bdeg_pkg::CFG_DEBOUNCE, 16'd0);
		write_reg(bdeg_pkg::CFG_LONG, 16'd0);
		write_reg(bdeg_pkg::CFG_RDELAY, 16'd0);
		write_reg(bdeg_pkg::CFG_RPERIOD, 16'd0);
		write_reg(bdeg_pkg::CFG_FAST_AFTER, 16'd0);
		write_reg(bdeg_pkg::CFG_FAST_PERIOD, 16'd0);
		random_phase(60, 1);
		// stall the receiver long so the block backs up its input
		hold_count = 300;
		drain();

		// Maximum values, clamped debounce
		write_reg(bdeg_pkg::CFG_POLL, 16'd255);
		write_reg(bdeg_pkg::CFG_DEBOUNCE, 16'd15);
		write_reg(bdeg_pkg::CFG_LONG, 16'hffff);
		write_reg(bdeg_pkg::CFG_RDELAY, 16'hffff);
		write_reg(bdeg_pkg::CFG_RPERIOD, 16'hffff);
		write_reg(bdeg_pkg::CFG_FAST_AFTER, 16'hffff);
		write_reg(bdeg_pkg::CFG_FAST_PERIOD, 16'hffff);
		random_phase(40, 255);
		for (int t = 0; t < 4; t++) add_poll(32'h7fff_0000, 5'($urandom()));
		drain();

		// Mid settings with random bits in the register values
		repeat (3) begin
			write_reg(bdeg_pkg::CFG_POLL, 16'($urandom_range(1, 20)));
			write_reg(bdeg_pkg::CFG_DEBOUNCE, 16'($urandom_range(1, 8)));
			write_reg(bdeg_pkg::CFG_LONG, 16'($urandom_range(0, 300)));
			write_reg(bdeg_pkg::CFG_RDELAY, 16'($urandom_range(0, 200)));
			write_reg(bdeg_pkg::CFG_RPERIOD, 16'($urandom_range(1, 60)));
			write_reg(bdeg_pkg::CFG_FAST_AFTER, 16'($urandom_range(0, 400)));
			write_reg(bdeg_pkg::CFG_FAST_PERIOD, 16'($urandom_range(1, 20)));
			random_phase(60, $urandom_range(5, 25));
			drain();
		end

		if (fail_count == 0) begin
			$display("button_debounce_event_generator_top_test passed");
		end else begin
			$display("button_debounce_event_generator_top_test failed");
		end
		$finish;
	end
endmodule
